[sv/mrsh_pkg.sv]
// Shared types and constants for the string history block.
package mrsh_pkg;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [1:0] ST_INS  = 2'd0;
	localparam logic [1:0] ST_IGN  = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	localparam logic [7:0] BLANK_BYTE = 8'h20;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] rbyte;
		logic       valid;
	} res_t;

endpackage

[sv/mrsh_front.sv]
// Front end: staging counters, item classification and command build.
module mrsh_front #(
	parameter int NUM_STACKS = 4,
	parameter int CAPACITY   = 1024,
	parameter int MAX_STRING = 256,
	parameter int LW         = $clog2(MAX_STRING + 1),
	parameter int CW         = LW + 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          func,
	input  logic [1:0]    stack_id,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic [8:0]    entry_index,
	input  logic [7:0]    byte_offset,
	output logic          cmd_push,
	output logic [CW-1:0] cmd
);

	typedef struct packed {
		logic          func;
		logic          stage;
		logic          last;
		logic [1:0]    sid;
		logic [7:0]    dbyte;
		logic [LW-1:0] len;
		logic [1:0]    status;
		logic          miss;
		logic [8:0]    idx;
		logic [7:0]    off;
	} cmd_t;

	logic [LW-1:0] len_q, nlen;
	logic          nb_q, nnb, done_q, ndone, stage_en, miss;
	cmd_t          c;

	assign miss = 32'(stack_id) >= NUM_STACKS;

	always_comb begin
		nlen     = len_q;
		nnb      = nb_q;
		ndone    = done_q;
		stage_en = 1'b0;
		if (!done_q) begin
			if (data_byte == 8'd0) begin
				ndone = 1'b1;
			end else if (32'(len_q) < MAX_STRING) begin
				stage_en = 1'b1;
				nlen     = len_q + LW'(1);
				if (data_byte != mrsh_pkg::BLANK_BYTE) begin
					nnb = 1'b1;
				end
			end
		end
		c        = '0;
		c.func   = func;
		c.sid    = stack_id;
		c.dbyte  = data_byte;
		c.idx    = entry_index;
		c.off    = byte_offset;
		c.miss   = miss;
		c.len    = nlen;
		c.last   = last_byte;
		c.stage  = (func == mrsh_pkg::FUNC_PUSH) && stage_en;
		if (miss || nlen == '0 || !nnb) begin
			c.status = mrsh_pkg::ST_IGN;
		end else if (32'(nlen) >= MAX_STRING || 32'(nlen) + 1 > CAPACITY) begin
			c.status = mrsh_pkg::ST_LONG;
		end else begin
			c.status = mrsh_pkg::ST_INS;
		end
		cmd_push = accept && (func == mrsh_pkg::FUNC_READ || stage_en || last_byte);
		cmd      = c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			nb_q   <= 1'b0;
			done_q <= 1'b0;
		end else if (accept && func == mrsh_pkg::FUNC_PUSH) begin
			if (last_byte) begin
				len_q  <= '0;
				nb_q   <= 1'b0;
				done_q <= 1'b0;
			end else begin
				len_q  <= nlen;
				nb_q   <= nnb;
				done_q <= ndone;
			end
		end
	end

endmodule

[sv/mrsh_cmdq.sv]
// Short command queue between front end and back end.
module mrsh_cmdq #(
	parameter int CW    = 41,
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  logic [CW-1:0] wdata,
	input  logic          rd,
	output logic [CW-1:0] rdata,
	output logic          full,
	output logic          empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [CW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;

	assign full  = 32'(cnt_q) == DEPTH;
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + AW'(1);
			end
			if (rd) begin
				rp_q <= (32'(rp_q) == DEPTH - 1) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + NW'(wr) - NW'(rd);
		end
	end

endmodule

[sv/mrsh_back.sv]
// Back end: history and staging memories, commit and read sequencer.
module mrsh_back #(
	parameter int NUM_STACKS = 4,
	parameter int CAPACITY   = 1024,
	parameter int MAX_STRING = 256,
	parameter int LW         = $clog2(MAX_STRING + 1),
	parameter int CW         = LW + 33
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  logic [CW-1:0]  cmd,
	output logic           q_pop,
	input  logic           res_pop,
	output logic           res_valid,
	output mrsh_pkg::res_t res
);

	typedef struct packed {
		logic          func;
		logic          stage;
		logic          last;
		logic [1:0]    sid;
		logic [7:0]    dbyte;
		logic [LW-1:0] len;
		logic [1:0]    status;
		logic          miss;
		logic [8:0]    idx;
		logic [7:0]    off;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SCMP, S_MRD, S_MWR, S_SHSET, S_SHRD, S_SHWR,
		S_CPRD, S_CPWR, S_RRD, S_RCMP
	} state_t;

	localparam int PW  = $clog2(CAPACITY + 1);
	localparam int JW  = (PW > LW) ? PW : LW;
	localparam int SAW = $clog2(MAX_STRING);
	localparam int MD  = NUM_STACKS * CAPACITY;
	localparam int MW  = $clog2(MD);
	localparam int SIW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

	logic [7:0]     hist_mem [MD];
	logic [7:0]     stg_mem  [MAX_STRING];
	logic [7:0]     hrd_q, srd_q;

	cmd_t           c;
	state_t         state_q;
	logic [SIW-1:0] sidx_q;
	logic [MW-1:0]  base_q;
	logic [LW-1:0]  len_q;
	logic [8:0]     idx_q;
	logic [7:0]     off_q;
	logic [PW-1:0]  fill_w_q, p_q, pos_q, src_q, dst_q, k_q, n_q, o_q;
	logic [JW-1:0]  j_q;
	logic           match_q, trunc_q, kf_q;
	logic [PW-1:0]  fill_q [NUM_STACKS];
	logic [PW-1:0]  step;

	logic           h_ren, h_we, s_ren, s_we;
	logic [PW-1:0]  h_rp, h_wp;
	logic [7:0]     h_wdata;
	logic [SAW-1:0] s_raddr, s_waddr;

	assign c     = cmd;
	assign q_pop = (state_q == S_IDLE) && !q_empty && !res_valid;
	assign step  = PW'(32'(len_q) + 1);

	always_comb begin
		h_ren   = 1'b0;
		h_we    = 1'b0;
		s_ren   = 1'b0;
		h_rp    = p_q;
		h_wp    = dst_q;
		h_wdata = hrd_q;
		s_raddr = j_q[SAW-1:0];
		s_we    = q_pop && c.stage;
		s_waddr = SAW'(32'(c.len) - 1);
		case (state_q)
			S_SRD: begin
				if (p_q != fill_w_q) begin
					h_ren = 1'b1;
					s_ren = 1'b1;
				end
			end
			S_MRD: begin
				h_ren = src_q != fill_w_q;
				h_rp  = src_q;
			end
			S_MWR: begin
				h_we = 1'b1;
			end
			S_SHRD: begin
				h_ren = src_q != '0;
				h_rp  = src_q - PW'(1);
			end
			S_SHWR: begin
				h_we = 1'b1;
				h_wp = src_q - PW'(1) + step;
			end
			S_CPRD: begin
				if (32'(j_q) == 32'(len_q)) begin
					h_we    = 1'b1;
					h_wp    = PW'(len_q);
					h_wdata = 8'd0;
				end else begin
					s_ren = 1'b1;
				end
			end
			S_CPWR: begin
				h_we    = 1'b1;
				h_wp    = PW'(j_q);
				h_wdata = srd_q;
			end
			S_RRD: begin
				h_ren = p_q != fill_w_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			hist_mem[base_q + MW'(h_wp)] <= h_wdata;
		end
		if (h_ren) begin
			hrd_q <= hist_mem[base_q + MW'(h_rp)];
		end
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			stg_mem[s_waddr] <= c.dbyte;
		end
		if (s_ren) begin
			srd_q <= stg_mem[s_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_valid <= 1'b0;
			res       <= '0;
			for (int i = 0; i < NUM_STACKS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (res_valid && res_pop) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						sidx_q   <= SIW'(c.sid);
						base_q   <= MW'(32'(c.sid) * CAPACITY);
						len_q    <= c.len;
						idx_q    <= c.idx;
						off_q    <= c.off;
						fill_w_q <= fill_q[SIW'(c.sid)];
						p_q      <= '0;
						pos_q    <= '0;
						j_q      <= '0;
						n_q      <= '0;
						o_q      <= '0;
						match_q  <= 1'b1;
						if (c.func == mrsh_pkg::FUNC_READ) begin
							if (c.miss) begin
								res       <= '{mrsh_pkg::ST_READ, 8'd0, 1'b0};
								res_valid <= 1'b1;
							end else begin
								state_q <= S_RRD;
							end
						end else if (c.last) begin
							if (c.status != mrsh_pkg::ST_INS) begin
								res       <= '{c.status, 8'd0, 1'b0};
								res_valid <= 1'b1;
							end else begin
								state_q <= S_SRD;
							end
						end
					end
				end
				S_SRD: begin
					if (p_q == fill_w_q) begin
						if (match_q && 32'(j_q) == 32'(len_q)) begin
							if (pos_q == '0) begin
								res       <= '{mrsh_pkg::ST_IGN, 8'd0, 1'b0};
								res_valid <= 1'b1;
								state_q   <= S_IDLE;
							end else begin
								fill_w_q <= pos_q;
								state_q  <= S_SHSET;
							end
						end else begin
							state_q <= S_SHSET;
						end
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (hrd_q == 8'd0) begin
						if (match_q && 32'(j_q) == 32'(len_q)) begin
							if (pos_q == '0) begin
								res       <= '{mrsh_pkg::ST_IGN, 8'd0, 1'b0};
								res_valid <= 1'b1;
								state_q   <= S_IDLE;
							end else if (32'(p_q) + 1 <= 32'(fill_w_q)) begin
								src_q   <= p_q + PW'(1);
								dst_q   <= pos_q;
								state_q <= S_MRD;
							end else begin
								fill_w_q <= pos_q;
								state_q  <= S_SHSET;
							end
						end else begin
							pos_q   <= p_q + PW'(1);
							p_q     <= p_q + PW'(1);
							j_q     <= '0;
							match_q <= 1'b1;
							state_q <= S_SRD;
						end
					end else begin
						match_q <= match_q && (32'(j_q) < 32'(len_q)) && (hrd_q == srd_q);
						j_q     <= j_q + JW'(1);
						p_q     <= p_q + PW'(1);
						state_q <= S_SRD;
					end
				end
				S_MRD: begin
					if (src_q == fill_w_q) begin
						fill_w_q <= dst_q;
						state_q  <= S_SHSET;
					end else begin
						state_q <= S_MWR;
					end
				end
				S_MWR: begin
					src_q   <= src_q + PW'(1);
					dst_q   <= dst_q + PW'(1);
					state_q <= S_MRD;
				end
				S_SHSET: begin
					if (32'(fill_w_q) + 32'(step) <= CAPACITY) begin
						src_q   <= fill_w_q;
						trunc_q <= 1'b0;
					end else begin
						src_q   <= PW'(CAPACITY - 32'(step));
						trunc_q <= 1'b1;
					end
					kf_q    <= 1'b0;
					k_q     <= PW'(len_q);
					state_q <= S_SHRD;
				end
				S_SHRD: begin
					if (src_q == '0) begin
						j_q     <= '0;
						state_q <= S_CPRD;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					if (trunc_q && !kf_q && hrd_q == 8'd0) begin
						kf_q <= 1'b1;
						k_q  <= src_q - PW'(1) + step;
					end
					src_q   <= src_q - PW'(1);
					state_q <= S_SHRD;
				end
				S_CPRD: begin
					if (32'(j_q) == 32'(len_q)) begin
						fill_q[sidx_q] <= trunc_q ? k_q + PW'(1) : fill_w_q + step;
						res            <= '{mrsh_pkg::ST_INS, 8'd0, 1'b0};
						res_valid      <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						state_q <= S_CPWR;
					end
				end
				S_CPWR: begin
					j_q     <= j_q + JW'(1);
					state_q <= S_CPRD;
				end
				S_RRD: begin
					if (p_q == fill_w_q) begin
						res.status <= mrsh_pkg::ST_READ;
						res.rbyte  <= 8'd0;
						res.valid  <= (32'(n_q) == 32'(idx_q)) && (32'(o_q) == 32'(off_q)) &&
							(o_q != '0);
						res_valid  <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_RCMP;
					end
				end
				S_RCMP: begin
					if (32'(n_q) == 32'(idx_q)) begin
						if (32'(o_q) == 32'(off_q)) begin
							res       <= '{mrsh_pkg::ST_READ, hrd_q, 1'b1};
							res_valid <= 1'b1;
							state_q   <= S_IDLE;
						end else if (hrd_q == 8'd0) begin
							res       <= '{mrsh_pkg::ST_READ, 8'd0, 1'b0};
							res_valid <= 1'b1;
							state_q   <= S_IDLE;
						end else begin
							o_q     <= o_q + PW'(1);
							p_q     <= p_q + PW'(1);
							state_q <= S_RRD;
						end
					end else begin
						if (hrd_q == 8'd0) begin
							n_q <= n_q + PW'(1);
							o_q <= '0;
						end
						p_q     <= p_q + PW'(1);
						state_q <= S_RRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/mru_string_history.sv]
// Top level of the most-recently-used string history block.
// Usage:
//   Input queue side: raise push with an item on the fields; the item is
//   taken on a clock edge with push high and full low. A push item with
//   func 0 stages one string byte; last_byte commits the staged string to
//   history stack_id. A func 1 item reads one byte of entry entry_index.
//   Result queue side: while empty is low the oldest result is on status,
//   read_byte and read_valid; pop high takes it. Non-final push bytes make
//   no result.
//   A read walks the history one byte at a time. A commit compares over the
//   store and moves the tail over a removed duplicate (together one pass),
//   shifts the stored strings up to make room at the front and copies the
//   string in at the front.
//   Items enter a four-deep command queue at one per cycle until it fills.
//   A waiting result stalls the back end only; the front keeps queueing.
//   Reset empties every history through its fill count and clears the
//   staging counters at once; no clearing pass is needed.
module mru_string_history #(
	parameter int NUM_STACKS = 4,
	parameter int CAPACITY   = 1024,
	parameter int MAX_STRING = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       func,
	input  logic [1:0] stack_id,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic [8:0] entry_index,
	input  logic [7:0] byte_offset,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] status,
	output logic [7:0] read_byte,
	output logic       read_valid
);

	localparam int LW = $clog2(MAX_STRING + 1);
	localparam int CW = LW + 33;

	logic           accept, q_push, q_pop, q_full, q_empty, res_valid;
	logic [CW-1:0]  f_cmd, b_cmd;
	mrsh_pkg::res_t res;

	assign accept     = push && !q_full;
	assign full       = q_full;
	assign empty      = !res_valid;
	assign status     = res.status;
	assign read_byte  = res.rbyte;
	assign read_valid = res.valid;

	mrsh_front #(
		.NUM_STACKS(NUM_STACKS), .CAPACITY(CAPACITY), .MAX_STRING(MAX_STRING),
		.LW(LW), .CW(CW)
	) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .func(func),
		.stack_id(stack_id), .data_byte(data_byte), .last_byte(last_byte),
		.entry_index(entry_index), .byte_offset(byte_offset),
		.cmd_push(q_push), .cmd(f_cmd)
	);

	mrsh_cmdq #(.CW(CW), .DEPTH(4)) u_cmdq (
		.clk(clk), .arst_n(arst_n), .wr(q_push), .wdata(f_cmd), .rd(q_pop),
		.rdata(b_cmd), .full(q_full), .empty(q_empty)
	);

	mrsh_back #(
		.NUM_STACKS(NUM_STACKS), .CAPACITY(CAPACITY), .MAX_STRING(MAX_STRING),
		.LW(LW), .CW(CW)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .cmd(b_cmd),
		.q_pop(q_pop), .res_pop(pop), .res_valid(res_valid), .res(res)
	);

	a_q_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("command queue both full and empty");

	a_q_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command taken from empty queue");

	a_q_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command written into full queue");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !pop) |=> (res_valid && $stable(res)))
		else $error("waiting result changed before pop");

endmodule
